// ===== rtl/core/assert_macros.svh =====
// shared assertion macros for the decoder checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder port check failed");

// condition in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder port check failed");

`endif

// ===== rtl/core/u8dec_pkg.sv =====
`default_nettype none
package u8dec_pkg;

   // register map
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 13;
   localparam logic [CAP_W-1:0] CAP_RESET = 13'd257;

   typedef enum logic {
      REG_UTF16_OUTPUT   = 1'b0,
      REG_CAPACITY_LIMIT = 1'b1
   } reg_index_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_UNIT  = 2'd0,
      STATUS_END   = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   // utf-8 byte classes and code point limits
   localparam logic [7:0]  LEAD2_LO    = 8'hC2;
   localparam logic [7:0]  LEAD2_HI    = 8'hDF;
   localparam logic [7:0]  LEAD3_LO    = 8'hE0;
   localparam logic [7:0]  LEAD3_HI    = 8'hEF;
   localparam logic [7:0]  LEAD4_LO    = 8'hF0;
   localparam logic [7:0]  LEAD4_HI    = 8'hF4;
   localparam logic [20:0] CODE_MAX    = 21'h10FFFF;
   localparam logic [20:0] SURR_LO     = 21'h00D800;
   localparam logic [20:0] SURR_HI     = 21'h00DFFF;
   localparam logic [20:0] HIGH_SURR   = 21'h00D800;
   localparam logic [20:0] LOW_SURR    = 21'h00DC00;
   localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
   localparam logic [20:0] PLANE1_BASE = 21'h010000;
   localparam logic [16:0] MIN_TWO     = 17'h00080;
   localparam logic [16:0] MIN_THREE   = 17'h00800;
   localparam logic [16:0] MIN_FOUR    = 17'h10000;

   // result queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   typedef struct packed {
      logic [20:0] code;
      logic [11:0] index;
      status_type  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0]  pending;
      logic [20:0] acc;
      logic [16:0] minv;
      logic        err;
   } dec_state_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } step_out_type;

endpackage
`default_nettype wire

// ===== rtl/core/u8dec_step.sv =====
`default_nettype none
module u8dec_step #(
   parameter int MAX_UNITS = 4096
) (
   input  logic [7:0]                        byte_value,
   input  u8dec_pkg::dec_state_type          state_cur,
   input  logic [$clog2(MAX_UNITS)-1:0]      used_cur,
   input  logic                              utf16,
   input  logic [u8dec_pkg::CAP_W-1:0]       cap_limit,
   output u8dec_pkg::dec_state_type          state_nxt,
   output logic [$clog2(MAX_UNITS)-1:0]      used_nxt,
   output u8dec_pkg::step_out_type           step_out
);
   import u8dec_pkg::*;

   localparam int CntW = $clog2(MAX_UNITS);
   localparam int SumW = (CntW + 2 > CAP_W) ? CntW + 2 : CAP_W;

   logic [SumW-1:0] cap_ext;
   logic [SumW-1:0] cap_eff;
   logic [SumW-1:0] used_ext;
   logic [SumW-1:0] used_p1;
   logic [SumW-1:0] used_p2;
   logic            fit1;
   logic            fit2;
   logic [20:0]     acc_shift;
   logic [1:0]      pend_dec;
   logic            emit_req;
   logic [20:0]     emit_val;
   logic [16:0]     emit_min;
   logic            err_req;
   logic [19:0]     sup_off;
   logic [20:0]     sup_val;

   // capacity clamp and fit checks
   always_comb begin
      cap_ext  = SumW'(cap_limit);
      cap_eff  = (cap_ext > SumW'(MAX_UNITS)) ? SumW'(MAX_UNITS) : cap_ext;
      used_ext = SumW'(used_cur);
      used_p1  = used_ext + SumW'(1);
      used_p2  = used_ext + SumW'(2);
      fit1     = used_p1 < cap_eff;
      fit2     = used_p2 < cap_eff;
   end

   assign acc_shift = {state_cur.acc[14:0], byte_value[5:0]};
   assign pend_dec  = state_cur.pending - 2'd1;

   // byte classification and sequence tracking
   always_comb begin
      state_nxt = state_cur;
      used_nxt  = used_cur;
      step_out  = '0;
      emit_req  = 1'b0;
      emit_val  = '0;
      emit_min  = '0;
      err_req   = 1'b0;
      sup_val   = '0;
      sup_off   = '0;

      if (byte_value == 8'h00) begin
         // terminator: report unless an error was already reported, and start a fresh string
         state_nxt = '0;
         used_nxt  = '0;
         if (!state_cur.err) begin
            step_out.count     = 2'd1;
            step_out.r0.code   = '0;
            step_out.r0.index  = used_ext[11:0];
            step_out.r0.last   = 1'b1;
            if (state_cur.pending != 2'd0 || cap_eff == '0) begin
               step_out.r0.status = STATUS_ERROR;
            end else begin
               step_out.r0.status = STATUS_END;
            end
         end
      end else if (state_cur.err) begin
         // drop bytes until the terminator
      end else if (state_cur.pending != 2'd0) begin
         if (byte_value[7:6] != 2'b10) begin
            err_req = 1'b1;
         end else begin
            state_nxt.acc     = acc_shift;
            state_nxt.pending = pend_dec;
            if (pend_dec == 2'd0) begin
               emit_req = 1'b1;
               emit_val = acc_shift;
               emit_min = state_cur.minv;
            end
         end
      end else if (byte_value[7] == 1'b0) begin
         emit_req = 1'b1;
         emit_val = 21'(byte_value);
         emit_min = '0;
      end else if (byte_value inside {[LEAD2_LO:LEAD2_HI]}) begin
         state_nxt.acc     = 21'(byte_value[4:0]);
         state_nxt.pending = 2'd1;
         state_nxt.minv    = MIN_TWO;
      end else if (byte_value inside {[LEAD3_LO:LEAD3_HI]}) begin
         state_nxt.acc     = 21'(byte_value[3:0]);
         state_nxt.pending = 2'd2;
         state_nxt.minv    = MIN_THREE;
      end else if (byte_value inside {[LEAD4_LO:LEAD4_HI]}) begin
         state_nxt.acc     = 21'(byte_value[2:0]);
         state_nxt.pending = 2'd3;
         state_nxt.minv    = MIN_FOUR;
      end else begin
         err_req = 1'b1;
      end

      // range check and unit emission
      if (emit_req) begin
         sup_val = emit_val - PLANE1_BASE;
         sup_off = sup_val[19:0];
         if (emit_val < 21'(emit_min) || emit_val > CODE_MAX ||
             (emit_val >= SURR_LO && emit_val <= SURR_HI)) begin
            err_req = 1'b1;
         end else if (utf16 && emit_val > BMP_MAX) begin
            if (!fit2) begin
               err_req = 1'b1;
            end else begin
               step_out.count     = 2'd2;
               step_out.r0.code   = HIGH_SURR | 21'(sup_off[19:10]);
               step_out.r0.index  = used_ext[11:0];
               step_out.r0.status = STATUS_UNIT;
               step_out.r0.last   = 1'b0;
               step_out.r1.code   = LOW_SURR | 21'(sup_off[9:0]);
               step_out.r1.index  = used_p1[11:0];
               step_out.r1.status = STATUS_UNIT;
               step_out.r1.last   = 1'b1;
               used_nxt           = used_p2[CntW-1:0];
            end
         end else if (!fit1) begin
            err_req = 1'b1;
         end else begin
            step_out.count     = 2'd1;
            step_out.r0.code   = emit_val;
            step_out.r0.index  = used_ext[11:0];
            step_out.r0.status = STATUS_UNIT;
            step_out.r0.last   = 1'b1;
            used_nxt           = used_p1[CntW-1:0];
         end
      end

      // error result, then drop until the terminator
      if (err_req) begin
         step_out.count     = 2'd1;
         step_out.r0.code   = '0;
         step_out.r0.index  = used_ext[11:0];
         step_out.r0.status = STATUS_ERROR;
         step_out.r0.last   = 1'b1;
         state_nxt.err      = 1'b1;
         state_nxt.pending  = '0;
         state_nxt.acc      = '0;
         state_nxt.minv     = '0;
         used_nxt           = used_cur;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/utf8_to_code_unit_decoder_unit.sv =====
// UTF-8 decoder with validation: one byte of a zero-terminated string per
// transfer on req, code points (or UTF-16 surrogate pairs when register 0 is
// set) out on rsp, with an error result for malformed input or a full buffer
// and an end result for the terminator. A byte is taken every cycle as long as
// the four-entry result queue has two free slots; a byte is held in the input
// register, then its results are written into the result queue that drives
// rsp, and the sustained rate is one byte per cycle while rsp keeps pace.
// Registers: 0x0 utf16_output (bit 0), 0x4 capacity_limit
// (bits 12:0, reset 257); write them only while the block is idle.
`default_nettype none
module utf8_to_code_unit_decoder_unit #(
   parameter int MAX_UNITS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_byte_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [20:0]                       rsp_code_unit,
   output logic [11:0]                       rsp_unit_index,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last_of_run,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [u8dec_pkg::ADDR_W-1:0]      paddr,
   input  logic [u8dec_pkg::DATA_W-1:0]      pwdata,
   output logic [u8dec_pkg::DATA_W-1:0]      prdata,
   output logic                              pready
);
   import u8dec_pkg::*;

   localparam int CntW = $clog2(MAX_UNITS);

   logic                 utf16_ff;
   logic [CAP_W-1:0]     cap_ff;
   reg_index_type        reg_sel;
   logic                 csr_write;

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 fire;

   dec_state_type        state_ff;
   dec_state_type        state_in;
   logic [CntW-1:0]      used_ff;
   logic [CntW-1:0]      used_in;
   step_out_type         step_out;

   result_type           q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   head_ff;
   logic [Q_PTR_W-1:0]   tail_ff;
   logic [Q_PTR_W-1:0]   tail_p1;
   logic [Q_CNT_W-1:0]   cnt_ff;
   logic [Q_CNT_W-1:0]   cnt_in;
   logic                 pop;
   result_type           head_res;

   // configuration port
   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         utf16_ff <= 1'b0;
         cap_ff   <= CAP_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            REG_UTF16_OUTPUT:   utf16_ff <= pwdata[0];
            REG_CAPACITY_LIMIT: cap_ff   <= pwdata[CAP_W-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_UTF16_OUTPUT:   prdata = DATA_W'(utf16_ff);
         REG_CAPACITY_LIMIT: prdata = DATA_W'(cap_ff);
         default:            prdata = '0;
      endcase
   end

   // input register
   assign fire      = in_valid_ff && (cnt_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_value;
      end
   end

   // decode step
   u8dec_step #(
      .MAX_UNITS(MAX_UNITS)
   ) u_step (
      .byte_value(in_byte_ff),
      .state_cur (state_ff),
      .used_cur  (used_ff),
      .utf16     (utf16_ff),
      .cap_limit (cap_ff),
      .state_nxt (state_in),
      .used_nxt  (used_in),
      .step_out  (step_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         used_ff  <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   // result queue
   assign tail_p1  = tail_ff + Q_PTR_W'(1);
   assign head_res = q_ff[head_ff];
   assign pop      = rsp_valid && rsp_ready;
   assign cnt_in   = cnt_ff + (fire ? Q_CNT_W'(step_out.count) : '0) - Q_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (pop) begin
            head_ff <= head_ff + Q_PTR_W'(1);
         end
         if (fire) begin
            tail_ff <= tail_ff + Q_PTR_W'(step_out.count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_out.count != 2'd0) begin
         q_ff[tail_ff] <= step_out.r0;
      end
      if (fire && step_out.count == 2'd2) begin
         q_ff[tail_p1] <= step_out.r1;
      end
   end

   // result channel
   assign rsp_valid       = cnt_ff != '0;
   assign rsp_code_unit   = head_res.code;
   assign rsp_unit_index  = head_res.index;
   assign rsp_status      = head_res.status;
   assign rsp_last_of_run = head_res.last;

endmodule
`default_nettype wire

// ===== rtl/core/u8dec_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module u8dec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] rsp_code_unit,
   input logic [11:0] rsp_unit_index,
   input logic [1:0]  rsp_status,
   input logic        rsp_last_of_run
);
   import u8dec_pkg::*;

   logic        rsp_stall;
   logic        rsp_nonunit;
   logic        nonunit_ok;
   logic        pair_first;
   logic        pair_fire;
   logic        high_ok;
   logic [11:0] idx_p1;
   logic [34:0] rsp_payload;

   // port-level views of the result channel
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_code_unit, rsp_unit_index, rsp_status};
   assign rsp_nonunit = rsp_valid && rsp_status != STATUS_UNIT;
   assign nonunit_ok  = rsp_code_unit == '0 && rsp_last_of_run;
   assign pair_first  = rsp_valid && !rsp_last_of_run;
   assign pair_fire   = pair_first && rsp_ready;
   assign high_ok     = rsp_status == STATUS_UNIT && rsp_code_unit[20:10] == HIGH_SURR[20:10];
   assign idx_p1      = rsp_unit_index + 12'd1;

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // end and error results carry no code and close the run
   `ASSERT_SAME(a_nonunit_zero, clock, reset, rsp_nonunit, nonunit_ok)

   // first half of a pair is a high surrogate
   `ASSERT_SAME(a_pair_high, clock, reset, pair_first, high_ok)

   // second half of a pair is ready right behind the first
   `ASSERT_NEXT(a_pair_follow, clock, reset, pair_fire, rsp_valid && rsp_unit_index == $past(idx_p1))

endmodule

bind utf8_to_code_unit_decoder_unit u8dec_checker u_checker (.*);
`default_nettype wire
